/* sv/fcpq_pkg.sv */
`default_nettype none

package fcpq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CLASS_COUNT = 4;
  localparam int MAX_RESULTS = 32;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CLS_W  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);
  localparam int ADDR_W = CLS_W + PTR_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  localparam logic [1:0] BASICO = 2'd3;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_SERVE   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEEK,
    ST_CHK
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] customer_id;
    logic [1:0]  priority_class;
    logic [9:0]  service_minutes;
    logic [15:0] time_budget;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_customer_id;
    logic [1:0]  out_priority_class;
    logic [9:0]  out_service_minutes;
    logic        removed;
    logic        dropped_full;
    logic [15:0] remaining_budget;
    logic [15:0] total_waiting_minutes;
    logic [5:0]  entries_left;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [9:0]  minutes;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* sv/fcpq_ram.sv */
`default_nettype none

module fcpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/four_class_priority_queue.sv */
`default_nettype none

// Strict-priority queue with four classes sharing 32 entries; class 0 leaves first and each
// class is first in, first out. An item is taken when start is high and busy is low, and busy
// falls in the cycle that shows the item's last result, so the next item can be taken then.
// Results appear on out_item for one cycle each, marked by out_valid, and cannot be held off,
// so the receiver must take every one. Enqueue, the unused command and a dequeue of an empty
// queue show their result from the execute state, and a dequeue that removes an entry shows it
// from the check state. A serve command pops entries through seek and check states and stops in
// the seek state on an empty queue or the pop limit, or in the check state on a head that does
// not fit the budget; each pop waits for the entry store's registered read. Each served result
// is shown one pop later, so that the last flag is known.
module four_class_priority_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire fcpq_pkg::in_item_t in_item,
  output logic                    out_valid,
  output fcpq_pkg::res_t          out_item
);

  localparam int PTR_W = fcpq_pkg::PTR_W;
  localparam int CLS_W = fcpq_pkg::CLS_W;
  localparam int CNT_W = fcpq_pkg::CNT_W;
  localparam int NRES_W = fcpq_pkg::NRES_W;
  localparam int ADDR_W = fcpq_pkg::ADDR_W;

  fcpq_pkg::state_t   state_r, state_nxt;
  fcpq_pkg::in_item_t item_r, item_nxt;
  fcpq_pkg::res_t     out_r, out_nxt;
  fcpq_pkg::res_t     pend_r, pend_nxt;
  fcpq_pkg::entry_t   rd_entry, wr_entry;

  logic              out_valid_r, out_valid_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic [15:0]       budget_r, budget_nxt;
  logic [NRES_W-1:0] n_r, n_nxt;
  logic [PTR_W-1:0]  head_r [fcpq_pkg::CLASS_COUNT];
  logic [PTR_W-1:0]  head_nxt [fcpq_pkg::CLASS_COUNT];
  logic [PTR_W-1:0]  tail_r [fcpq_pkg::CLASS_COUNT];
  logic [PTR_W-1:0]  tail_nxt [fcpq_pkg::CLASS_COUNT];
  logic [CNT_W-1:0]  cnt_r [fcpq_pkg::CLASS_COUNT];
  logic [CNT_W-1:0]  cnt_nxt [fcpq_pkg::CLASS_COUNT];
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [15:0]       sum_r, sum_nxt;

  logic              any_nz;
  logic [CLS_W-1:0]  first_cls;
  logic [CLS_W-1:0]  enq_cls;
  logic              too_big;
  logic              seek_stop;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0]  total_pop;
  logic [15:0]       sum_pop, budget_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(fcpq_pkg::QUEUE_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PTR_W'(1);
    end
    return q;
  endfunction

  function automatic fcpq_pkg::res_t mark(input logic [15:0] budget,
                                          input logic [15:0] sum,
                                          input logic [CNT_W-1:0] total);
    fcpq_pkg::res_t r;
    r = '0;
    r.out_priority_class    = fcpq_pkg::BASICO;
    r.remaining_budget      = budget;
    r.total_waiting_minutes = sum;
    r.entries_left          = 6'(total);
    r.last                  = 1'b1;
    return r;
  endfunction

  fcpq_ram #(
    .WIDTH (fcpq_pkg::ENTRY_W),
    .DEPTH (fcpq_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  always_comb begin
    any_nz    = 1'b0;
    first_cls = '0;
    for (int c = fcpq_pkg::CLASS_COUNT - 1; c >= 0; c--) begin
      if (cnt_r[c] != '0) begin
        any_nz    = 1'b1;
        first_cls = CLS_W'(c);
      end
    end
  end

  always_comb begin
    if (int'(item_r.priority_class) >= fcpq_pkg::CLASS_COUNT) begin
      enq_cls = CLS_W'(fcpq_pkg::CLASS_COUNT - 1);
    end else begin
      enq_cls = CLS_W'(item_r.priority_class);
    end
  end

  assign rd_addr    = {first_cls, head_r[first_cls]};
  assign too_big    = {6'd0, rd_entry.minutes} > budget_r;
  assign seek_stop  = (n_r == NRES_W'(fcpq_pkg::MAX_RESULTS)) || !any_nz;
  assign total_pop  = total_r - CNT_W'(1);
  assign sum_pop    = sum_r - 16'(rd_entry.minutes);
  assign budget_pop = budget_r - 16'(rd_entry.minutes);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcpq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = fcpq_pkg::ST_EXEC;
        end
      end
      fcpq_pkg::ST_EXEC: begin
        case (item_r.command)
          fcpq_pkg::CMD_DEQUEUE: state_nxt = any_nz ? fcpq_pkg::ST_CHK : fcpq_pkg::ST_IDLE;
          fcpq_pkg::CMD_SERVE:   state_nxt = fcpq_pkg::ST_SEEK;
          default:               state_nxt = fcpq_pkg::ST_IDLE;
        endcase
      end
      fcpq_pkg::ST_SEEK: begin
        state_nxt = seek_stop ? fcpq_pkg::ST_IDLE : fcpq_pkg::ST_CHK;
      end
      fcpq_pkg::ST_CHK: begin
        if (item_r.command == fcpq_pkg::CMD_DEQUEUE || too_big) begin
          state_nxt = fcpq_pkg::ST_IDLE;
        end else begin
          state_nxt = fcpq_pkg::ST_SEEK;
        end
      end
      default: state_nxt = fcpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    cls_nxt       = cls_r;
    budget_nxt    = budget_r;
    n_nxt         = n_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    sum_nxt       = sum_r;
    wr_en         = 1'b0;
    wr_addr       = {enq_cls, tail_r[enq_cls]};
    wr_entry.id      = item_r.customer_id;
    wr_entry.minutes = item_r.service_minutes;

    case (state_r)
      fcpq_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
        end
      end
      fcpq_pkg::ST_EXEC: begin
        cls_nxt = first_cls;
        case (item_r.command)
          fcpq_pkg::CMD_ENQUEUE: begin
            out_valid_nxt = 1'b1;
            if (total_r >= CNT_W'(fcpq_pkg::QUEUE_DEPTH)) begin
              out_nxt = mark(16'd0, sum_r, total_r);
              out_nxt.dropped_full = 1'b1;
            end else begin
              wr_en = 1'b1;
              for (int c = 0; c < fcpq_pkg::CLASS_COUNT; c++) begin
                if (CLS_W'(c) == enq_cls) begin
                  tail_nxt[c] = ptr_inc(tail_r[c]);
                  cnt_nxt[c]  = cnt_r[c] + CNT_W'(1);
                end
              end
              total_nxt = total_r + CNT_W'(1);
              sum_nxt   = sum_r + 16'(item_r.service_minutes);
              out_nxt   = mark(16'd0, sum_nxt, total_nxt);
            end
          end
          fcpq_pkg::CMD_DEQUEUE: begin
            if (!any_nz) begin
              out_valid_nxt = 1'b1;
              out_nxt       = mark(16'd0, sum_r, total_r);
            end
          end
          fcpq_pkg::CMD_SERVE: begin
            budget_nxt   = item_r.time_budget;
            n_nxt        = '0;
            pend_vld_nxt = 1'b0;
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_nxt       = mark(16'd0, sum_r, total_r);
          end
        endcase
      end
      fcpq_pkg::ST_SEEK: begin
        cls_nxt = first_cls;
        if (seek_stop) begin
          out_valid_nxt = 1'b1;
          pend_vld_nxt  = 1'b0;
          if (pend_vld_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt = mark(budget_r, sum_r, total_r);
          end
        end
      end
      fcpq_pkg::ST_CHK: begin
        if (item_r.command == fcpq_pkg::CMD_SERVE && too_big) begin
          out_valid_nxt = 1'b1;
          pend_vld_nxt  = 1'b0;
          if (pend_vld_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt = mark(budget_r, sum_r, total_r);
          end
        end else begin
          for (int c = 0; c < fcpq_pkg::CLASS_COUNT; c++) begin
            if (CLS_W'(c) == cls_r) begin
              head_nxt[c] = ptr_inc(head_r[c]);
              cnt_nxt[c]  = cnt_r[c] - CNT_W'(1);
            end
          end
          total_nxt = total_pop;
          sum_nxt   = sum_pop;
          pend_nxt.out_customer_id       = rd_entry.id;
          pend_nxt.out_priority_class    = 2'(cls_r);
          pend_nxt.out_service_minutes   = rd_entry.minutes;
          pend_nxt.removed               = 1'b1;
          pend_nxt.dropped_full          = 1'b0;
          pend_nxt.remaining_budget      = budget_pop;
          pend_nxt.total_waiting_minutes = sum_pop;
          pend_nxt.entries_left          = 6'(total_pop);
          pend_nxt.last                  = 1'b0;
          if (item_r.command == fcpq_pkg::CMD_DEQUEUE) begin
            out_valid_nxt                = 1'b1;
            out_nxt                      = pend_nxt;
            out_nxt.remaining_budget     = 16'd0;
            out_nxt.last                 = 1'b1;
          end else begin
            budget_nxt    = budget_pop;
            n_nxt         = n_r + NRES_W'(1);
            pend_vld_nxt  = 1'b1;
            out_valid_nxt = pend_vld_r;
            out_nxt       = pend_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcpq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      n_r         <= '0;
      total_r     <= '0;
      sum_r       <= '0;
      for (int c = 0; c < fcpq_pkg::CLASS_COUNT; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
      n_r         <= n_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    out_r    <= out_nxt;
    pend_r   <= pend_nxt;
    cls_r    <= cls_nxt;
    budget_r <= budget_nxt;
  end

  assign busy      = (state_r != fcpq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy)
    else $error("busy still high with the final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("intermediate result shown while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(fcpq_pkg::QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.dropped_full |->
      out_item.entries_left == 6'(fcpq_pkg::QUEUE_DEPTH) && !out_item.removed)
    else $error("item dropped while queue not full");
`endif

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import fcpq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 500;
  localparam int CALM_FROM = 430;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  class class_queues_mirror;
    entry_t lanes[CLASS_COUNT][$];
    int held;
    logic [15:0] minutes_held;
    res_t awaited[$];
    int mismatches;

    function new();
      held = 0;
      minutes_held = '0;
      mismatches = 0;
    endfunction

    function res_t shape(logic [15:0] id, logic [1:0] cls, logic [9:0] mins, logic taken,
                         logic full, logic [15:0] budget_left, logic fin);
      res_t r;
      r.out_customer_id = id;
      r.out_priority_class = cls;
      r.out_service_minutes = mins;
      r.removed = taken;
      r.dropped_full = full;
      r.remaining_budget = budget_left;
      r.total_waiting_minutes = minutes_held;
      r.entries_left = 6'(held);
      r.last = fin;
      return r;
    endfunction

    function int top_lane();
      for (int c = 0; c < CLASS_COUNT; c++) begin
        if (lanes[c].size() != 0) return c;
      end
      return CLASS_COUNT;
    endfunction

    function entry_t pop_lane(int c);
      entry_t e;
      e = lanes[c].pop_front();
      held--;
      minutes_held = minutes_held - 16'(e.minutes);
      return e;
    endfunction

    function void note_command(in_item_t it);
      int c;
      int n;
      entry_t e;
      logic [15:0] budget;
      case (it.command)
        CMD_ENQUEUE: begin
          c = (int'(it.priority_class) >= CLASS_COUNT) ? CLASS_COUNT - 1 : int'(it.priority_class);
          if (held >= QUEUE_DEPTH) begin
            awaited.push_back(shape('0, BASICO, '0, 1'b0, 1'b1, '0, 1'b1));
          end else begin
            e.id = it.customer_id;
            e.minutes = it.service_minutes;
            lanes[c].push_back(e);
            held++;
            minutes_held = minutes_held + 16'(it.service_minutes);
            awaited.push_back(shape('0, BASICO, '0, 1'b0, 1'b0, '0, 1'b1));
          end
        end
        CMD_DEQUEUE: begin
          c = top_lane();
          if (c >= CLASS_COUNT) begin
            awaited.push_back(shape('0, BASICO, '0, 1'b0, 1'b0, '0, 1'b1));
          end else begin
            e = pop_lane(c);
            awaited.push_back(shape(e.id, 2'(c), e.minutes, 1'b1, 1'b0, '0, 1'b1));
          end
        end
        CMD_SERVE: begin
          budget = it.time_budget;
          n = 0;
          while (n < MAX_RESULTS) begin
            c = top_lane();
            if (c >= CLASS_COUNT) break;
            if (16'(lanes[c][0].minutes) > budget) break;
            e = pop_lane(c);
            budget = budget - 16'(e.minutes);
            awaited.push_back(shape(e.id, 2'(c), e.minutes, 1'b1, 1'b0, budget, 1'b0));
            n++;
          end
          if (n == 0) begin
            awaited.push_back(shape('0, BASICO, '0, 1'b0, 1'b0, budget, 1'b1));
          end else begin
            awaited[awaited.size() - 1].last = 1'b1;
          end
        end
        default: begin
          awaited.push_back(shape('0, BASICO, '0, 1'b0, 1'b0, '0, 1'b1));
        end
      endcase
    endfunction

    function string describe(res_t r);
      return $sformatf("id=%h cls=%0d min=%0d rm=%b drop=%b budget=%0d wait=%0d left=%0d last=%b",
                       r.out_customer_id, r.out_priority_class, r.out_service_minutes,
                       r.removed, r.dropped_full, r.remaining_budget,
                       r.total_waiting_minutes, r.entries_left, r.last);
    endfunction

    function void check_result(res_t got);
      res_t want;
      bit bad;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = awaited.pop_front();
      bad = (got.out_customer_id !== want.out_customer_id) ||
            (got.out_priority_class !== want.out_priority_class) ||
            (got.out_service_minutes !== want.out_service_minutes) ||
            (got.removed !== want.removed) ||
            (got.dropped_full !== want.dropped_full) ||
            (got.remaining_budget !== want.remaining_budget) ||
            (got.total_waiting_minutes !== want.total_waiting_minutes) ||
            (got.entries_left !== want.entries_left) ||
            (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected %s", $time, describe(want));
          $display("                  actual   %s", describe(got));
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy;
  logic out_valid;
  res_t out_item;

  class_queues_mirror mirror = new();
  int sent = 0;
  int quiet_cycles = 0;
  bit pacing = 1'b0;

  always #5 clk = ~clk;

  four_class_priority_queue uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) mirror.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t item_of(cmd_t code, logic [15:0] id, logic [1:0] cls,
                                       logic [9:0] mins, logic [15:0] budget);
    in_item_t it;
    it.command = code;
    it.customer_id = id;
    it.priority_class = cls;
    it.service_minutes = mins;
    it.time_budget = budget;
    return it;
  endfunction

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  task automatic issue(in_item_t it);
    if (pacing && sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
      pause_sender($urandom_range(1, 19));
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_command(it);
    sent++;
  endtask

  function automatic logic [15:0] pick_budget();
    case ($urandom_range(0, 2))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 2047));
      default: return 16'hFFFF;
    endcase
  endfunction

  initial begin
    int mode;
    int count;
    int pick;
    bit tiny;
    cmd_t code;
    in_item_t it;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    issue(item_of(CMD_DEQUEUE, 16'hFFFF, 2'd3, 10'h3FF, 16'hFFFF));
    issue(item_of(CMD_SERVE, 16'h0000, 2'd0, 10'h000, 16'h0000));
    issue(item_of(CMD_SERVE, 16'hFFFF, 2'd3, 10'h3FF, 16'hFFFF));
    issue(item_of(cmd_t'(CMD_UNUSED), 16'hFFFF, 2'd3, 10'h3FF, 16'hFFFF));
    issue(item_of(CMD_ENQUEUE, 16'hFFFF, 2'd3, 10'd1023, 16'hFFFF));
    issue(item_of(CMD_ENQUEUE, 16'h0000, 2'd0, 10'd0, 16'h0000));
    issue(item_of(CMD_ENQUEUE, 16'h1234, 2'd1, 10'd1, 16'h0000));
    issue(item_of(CMD_ENQUEUE, 16'hA5A5, 2'd2, 10'd512, 16'h0000));
    issue(item_of(CMD_ENQUEUE, 16'h5A5A, 2'd0, 10'd1023, 16'h0000));
    issue(item_of(CMD_SERVE, 16'h0000, 2'd0, 10'd0, 16'd0));
    issue(item_of(CMD_SERVE, 16'h0000, 2'd0, 10'd0, 16'd1022));
    issue(item_of(CMD_DEQUEUE, 16'h0000, 2'd0, 10'd0, 16'd0));
    issue(item_of(CMD_SERVE, 16'h0000, 2'd0, 10'd0, 16'd513));
    issue(item_of(cmd_t'(CMD_UNUSED), 16'h0000, 2'd0, 10'd0, 16'h0000));
    issue(item_of(CMD_SERVE, 16'h0000, 2'd0, 10'd0, 16'hFFFF));
    issue(item_of(CMD_DEQUEUE, 16'h0000, 2'd0, 10'd0, 16'h0000));
    wait_drained();

    while (sent < ITEM_TARGET) begin
      mode = $urandom_range(0, 3);
      pacing = ($urandom_range(0, 2) != 0);
      case (mode)
        0: begin
          tiny = 1'($urandom_range(0, 1));
          count = $urandom_range(10, 45);
          repeat (count) begin
            if ($urandom_range(0, 9) < 8) begin
              it = item_of(CMD_ENQUEUE, 16'($urandom), 2'($urandom),
                           tiny ? 10'($urandom_range(0, 15)) : 10'($urandom), 16'($urandom));
            end else begin
              it = item_of(cmd_t'(2'($urandom_range(1, 3))), 16'($urandom), 2'($urandom),
                           10'($urandom), pick_budget());
            end
            issue(it);
          end
        end
        1: begin
          count = $urandom_range(5, 20);
          repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) code = CMD_DEQUEUE;
            else if (pick < 8) code = CMD_SERVE;
            else if (pick == 8) code = CMD_ENQUEUE;
            else code = cmd_t'(CMD_UNUSED);
            issue(item_of(code, 16'($urandom), 2'($urandom), 10'($urandom), pick_budget()));
          end
        end
        2: begin
          count = $urandom_range(5, 30);
          repeat (count) begin
            issue(item_of(cmd_t'(2'($urandom_range(0, 3))), 16'($urandom), 2'($urandom),
                          10'($urandom), 16'($urandom)));
          end
        end
        default: begin
          issue(item_of(CMD_SERVE, 16'($urandom), 2'($urandom), 10'($urandom), 16'hFFFF));
        end
      endcase
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    start <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
